### hdl/scp_pkg.sv
// Shared types and constants of the symmetric cross-product unit.
package scp_pkg;

  localparam int unsigned ElemW      = 16;
  localparam int unsigned RowCntW    = 9;
  localparam int unsigned ColCntW    = 4;
  localparam int unsigned IdxW       = 3;
  localparam int unsigned ValueW     = 64;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = 9;
  localparam int unsigned DefMaxCols = 8;
  localparam int unsigned DefMaxRows = 256;

  localparam logic [CfgIdxW-1:0] CfgRowCount = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgColCount = 1'b1;

  localparam logic [RowCntW-1:0] RowCountReset = 9'd256;
  localparam logic [ColCntW-1:0] ColCountReset = 4'd8;

  typedef struct packed {
    logic               err;
    logic [RowCntW-1:0] rows;
    logic [ColCntW-1:0] cols;
  } job_t;

  typedef enum logic [1:0] {
    BackIdle,
    BackRun,
    BackEmit
  } back_state_e;

endpackage

### hdl/scp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module scp_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 2048
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hdl/scp_front.sv
// Front part: configuration, element loading and run classification.
module scp_front #(
  parameter int unsigned MaxRows = scp_pkg::DefMaxRows,
  parameter int unsigned MaxCols = scp_pkg::DefMaxCols,
  parameter int unsigned AddrW   = 11
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [scp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [scp_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [scp_pkg::ElemW-1:0]     a_i,
  input  logic [scp_pkg::ElemW-1:0]     b_i,
  input  logic                          last_i,
  output logic                          we_o,
  output logic [AddrW-1:0]              waddr_o,
  output logic [scp_pkg::ElemW-1:0]     a_wdata_o,
  output logic [scp_pkg::ElemW-1:0]     b_wdata_o,
  output logic                          push_o,
  output scp_pkg::job_t                 job_o,
  input  logic                          q_full_i,
  input  logic                          done_i
);
  import scp_pkg::*;

  localparam int unsigned Depth = MaxRows * MaxCols;
  localparam int unsigned LcW   = $clog2(Depth + 1);
  localparam int unsigned PrW   = RowCntW + ColCntW;
  localparam int unsigned CmpW  = LcW > PrW ? LcW : PrW;

  logic [RowCntW-1:0] row_q;
  logic [ColCntW-1:0] col_q;
  logic [LcW-1:0]     cnt_q, cnt_new;
  logic               ovf_q, ovf_new, full, accept, bad, pend_q;
  logic [PrW-1:0]     expect_cnt;

  assign accept     = in_valid_i && in_ready_o;
  assign full       = cnt_q == LcW'(Depth);
  assign cnt_new    = full ? cnt_q : cnt_q + LcW'(1);
  assign ovf_new    = ovf_q | full;
  assign expect_cnt = PrW'(row_q) * PrW'(col_q);
  assign bad = (row_q == '0) || (32'(row_q) > MaxRows) || (col_q == '0) ||
               (32'(col_q) > MaxCols) || ovf_new ||
               (CmpW'(cnt_new) != CmpW'(expect_cnt));

  // Hold input while a good run is still being computed from the stores or the queue is full.
  assign in_ready_o = !pend_q && !q_full_i;
  assign we_o       = accept && !full;
  assign waddr_o    = cnt_q[AddrW-1:0];
  assign a_wdata_o  = a_i;
  assign b_wdata_o  = b_i;
  assign push_o     = accept && last_i;
  assign job_o      = '{err: bad, rows: row_q, cols: col_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= RowCountReset;
      col_q  <= ColCountReset;
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgRowCount: row_q <= cfg_data_i;
          CfgColCount: col_q <= cfg_data_i[ColCntW-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        cnt_q <= last_i ? '0 : cnt_new;
        ovf_q <= last_i ? 1'b0 : ovf_new;
      end
      if (done_i) begin
        pend_q <= 1'b0;
      end else if (push_o && !bad) begin
        pend_q <= 1'b1;
      end
    end
  end

endmodule

### hdl/scp_queue.sv
// Two-entry job queue between the front and back parts.
module scp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  scp_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output scp_pkg::job_t job_o
);
  import scp_pkg::*;

  job_t       slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign job_o   = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

### hdl/scp_back.sv
// Back part: dot-product sequencer, multiply-accumulate and result register.
module scp_back #(
  parameter int unsigned MaxRows = scp_pkg::DefMaxRows,
  parameter int unsigned AddrW   = 11
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         job_valid_i,
  input  scp_pkg::job_t                job_i,
  output logic                         pop_o,
  output logic [AddrW-1:0]             a_raddr_o,
  output logic [AddrW-1:0]             b_raddr_o,
  input  logic [scp_pkg::ElemW-1:0]    a_rdata_i,
  input  logic [scp_pkg::ElemW-1:0]    b_rdata_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [scp_pkg::IdxW-1:0]     row_o,
  output logic [scp_pkg::IdxW-1:0]     col_o,
  output logic [scp_pkg::ValueW-1:0]   value_o,
  output logic                         status_o,
  output logic                         last_o,
  output logic                         done_o
);
  import scp_pkg::*;

  // Sums of MaxRows products of 2^30 magnitude fit here: no saturation occurs.
  localparam int unsigned AccW = 2 * ElemW + $clog2(MaxRows + 1) + 1;
  localparam int unsigned SumW = IdxW + RowCntW + 1;

  back_state_e state_q, state_d;
  job_t                job_q;
  logic [IdxW-1:0]     p_q, q_q, i_w, j_w, last_idx;
  logic [RowCntW-1:0]  k_q;
  logic                v1_q, v2_q, issuing, last_entry;
  logic signed [ElemW-1:0]   a_s, b_s;
  logic signed [2*ElemW-1:0] prod_q;
  logic signed [AccW-1:0]    acc_q;
  logic [SumW-1:0]     a_sum, b_sum;

  assign i_w        = p_q > q_q ? p_q : q_q;
  assign j_w        = p_q > q_q ? q_q : p_q;
  assign last_idx   = IdxW'(job_q.cols - ColCntW'(1));
  assign last_entry = (p_q == last_idx) && (q_q == last_idx);
  assign issuing    = (state_q == BackRun) && (k_q < job_q.rows);
  assign a_sum      = SumW'(i_w) * SumW'(job_q.rows) + SumW'(k_q);
  assign b_sum      = SumW'(j_w) * SumW'(job_q.rows) + SumW'(k_q);
  assign a_raddr_o  = AddrW'(a_sum);
  assign b_raddr_o  = AddrW'(b_sum);
  assign a_s        = a_rdata_i;
  assign b_s        = b_rdata_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BackIdle: if (job_valid_i) state_d = job_i.err ? BackEmit : BackRun;
      BackRun:  if (!issuing && !v1_q && !v2_q) state_d = BackEmit;
      BackEmit: if (out_ready_i) begin
        state_d = (job_q.err || last_entry) ? BackIdle : BackRun;
      end
      default:  state_d = BackIdle;
    endcase
  end

  always_comb begin
    pop_o       = 1'b0;
    out_valid_o = 1'b0;
    done_o      = 1'b0;
    unique case (state_q)
      BackIdle: pop_o = job_valid_i;
      BackRun:  ;
      BackEmit: begin
        out_valid_o = 1'b1;
        done_o      = out_ready_i && !job_q.err && last_entry;
      end
      default:  ;
    endcase
  end

  assign row_o    = p_q;
  assign col_o    = q_q;
  assign value_o  = job_q.err ? '0 : ValueW'(acc_q);
  assign status_o = job_q.err;
  assign last_o   = job_q.err || last_entry;

  always_ff @(posedge clk_i) begin
    prod_q <= a_s * b_s;
    if (pop_o) begin
      job_q <= job_i;
      p_q   <= '0;
      q_q   <= '0;
      k_q   <= '0;
      acc_q <= '0;
    end else if (state_q == BackRun) begin
      if (issuing) k_q <= k_q + RowCntW'(1);
      if (v2_q)    acc_q <= acc_q + AccW'(prod_q);
    end else if (state_q == BackEmit && out_ready_i) begin
      // Advance row-major over the square result.
      if (q_q == last_idx) begin
        q_q <= '0;
        p_q <= p_q + IdxW'(1);
      end else begin
        q_q <= q_q + IdxW'(1);
      end
      k_q   <= '0;
      acc_q <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BackIdle;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      v1_q    <= issuing;
      v2_q    <= v1_q;
    end
  end

endmodule

### hdl/symmetric_cross_product_unit.sv
// Top level of the symmetric cross-product unit (C = A' * B, mirrored).
// Loading: one element pair per cycle while s_axis_tready_o is high, one transaction per cycle into the stores.
// Compute: for each of the n*n entries, one store read per row passes the read,
//   multiply and accumulate stages; the entry then waits in the result register
//   until the output takes it.
// An error run gives its one result once its job has passed the queue to an idle
//   back part, later behind earlier results or an output stall.
// Reset (rst_ni, asynchronous, active low) clears control state and the config
//   registers to row_count 256, col_count 8; the element stores are not cleared.
module symmetric_cross_product_unit #(
  parameter int unsigned MaxRows = scp_pkg::DefMaxRows,
  parameter int unsigned MaxCols = scp_pkg::DefMaxCols
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write port.
  input  logic                         cfg_we_i,
  input  logic [scp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [scp_pkg::CfgDataW-1:0] cfg_data_i,
  // Element stream.
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [31:0]                  s_axis_tdata_i,  // a_elem[15:0], b_elem[31:16]
  input  logic                         s_axis_tlast_i,  // last_elem
  // Result stream.
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [71:0]                  m_axis_tdata_o,  // row_index[2:0], col_index[5:3],
                                                        // entry_value[69:6], zero[71:70]
  output logic                         m_axis_tuser_o,  // status
  output logic                         m_axis_tlast_o   // last_result
);
  import scp_pkg::*;

  localparam int unsigned Depth = MaxRows * MaxCols;
  localparam int unsigned AddrW = Depth > 1 ? $clog2(Depth) : 1;

  logic             we, push, q_full, q_valid, pop, done;
  logic [AddrW-1:0] waddr, a_raddr, b_raddr;
  logic [ElemW-1:0] a_wdata, b_wdata, a_rdata, b_rdata;
  job_t             push_job, head_job;
  logic [IdxW-1:0]  row_idx, col_idx;
  logic [ValueW-1:0] value;

  // Front: take transactions, write the stores, classify each run at its last pair.
  scp_front #(.MaxRows(MaxRows), .MaxCols(MaxCols), .AddrW(AddrW)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .a_i        (s_axis_tdata_i[15:0]),
    .b_i        (s_axis_tdata_i[31:16]),
    .last_i     (s_axis_tlast_i),
    .we_o       (we),
    .waddr_o    (waddr),
    .a_wdata_o  (a_wdata),
    .b_wdata_o  (b_wdata),
    .push_o     (push),
    .job_o      (push_job),
    .q_full_i   (q_full),
    .done_i     (done)
  );

  // Queue of finished runs waiting for the back part.
  scp_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .job_o   (head_job)
  );

  scp_ram #(.Width(ElemW), .Depth(Depth)) u_a_store (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(a_wdata),
    .raddr_i(a_raddr), .rdata_o(a_rdata)
  );

  scp_ram #(.Width(ElemW), .Depth(Depth)) u_b_store (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(b_wdata),
    .raddr_i(b_raddr), .rdata_o(b_rdata)
  );

  // Back: form each entry's dot product and present it in the result register.
  scp_back #(.MaxRows(MaxRows), .AddrW(AddrW)) u_back (
    .clk_i, .rst_ni,
    .job_valid_i (q_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .a_raddr_o   (a_raddr),
    .b_raddr_o   (b_raddr),
    .a_rdata_i   (a_rdata),
    .b_rdata_i   (b_rdata),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .row_o       (row_idx),
    .col_o       (col_idx),
    .value_o     (value),
    .status_o    (m_axis_tuser_o),
    .last_o      (m_axis_tlast_o),
    .done_o      (done)
  );

  assign m_axis_tdata_o = {2'b00, value, col_idx, row_idx};

endmodule

### hdl/scp_checker.sv
// Port-level checker of the symmetric cross-product unit, with its bind.
module scp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [71:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  // A stalled result transaction holds its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("result changed while stalled");

  // An error result is alone, at the origin, with a zero value.
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |->
      m_axis_tlast_o && (m_axis_tdata_o == 72'd0))
    else $error("malformed error result");

  // The final entry of a good run lies on the diagonal.
  a_diag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o && !m_axis_tuser_o |->
      m_axis_tdata_o[2:0] == m_axis_tdata_o[5:3])
    else $error("last result off the diagonal");

endmodule

bind symmetric_cross_product_unit scp_checker u_scp_checker (
  .clk_i, .rst_ni, .m_axis_tvalid_o, .m_axis_tready_i,
  .m_axis_tdata_o, .m_axis_tuser_o, .m_axis_tlast_o
);

### tb/sv/tb.sv
// Testbench of the symmetric cross-product unit: directed and random streams checked against a predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import scp_pkg::*;

  localparam int unsigned StoreDepth = DefMaxRows * DefMaxCols;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned StallHold  = 400;
  localparam int unsigned SettleWait = 20;
  localparam int unsigned ItemTarget = 150;
  localparam int unsigned RunCap     = 40;

  // One expected result entry.
  typedef struct {
    logic [IdxW-1:0]          row;
    logic [IdxW-1:0]          col;
    logic signed [ValueW-1:0] value;
    logic                     status;
    logic                     last;
  } entry_t;

  // Scoreboard: keeps its own element stores, counters and configuration.
  class cross_product_board;
    logic [ElemW-1:0]   a_mem[StoreDepth];
    logic [ElemW-1:0]   b_mem[StoreDepth];
    int unsigned        loaded;
    bit                 overflowed;
    logic [RowCntW-1:0] rows;
    logic [ColCntW-1:0] cols;
    entry_t             pending_q[$];
    int unsigned        errors;

    function new();
      loaded     = 0;
      overflowed = 0;
      rows       = RowCountReset;
      cols       = ColCountReset;
      errors     = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      if (idx == CfgRowCount) rows = val[RowCntW-1:0];
      else cols = val[ColCntW-1:0];
    endfunction

    // Dot product of column ca of A with column cb of B; sums of Q8.24 products
    // stay far below the 64-bit range, so saturation never engages.
    function longint column_dot(int unsigned ca, int unsigned cb);
      longint acc;
      acc = 0;
      for (int unsigned k = 0; k < rows; k++) begin
        acc += longint'($signed(a_mem[(ca * rows + k) % StoreDepth])) *
               longint'($signed(b_mem[(cb * rows + k) % StoreDepth]));
      end
      return acc;
    endfunction

    // Store an accepted element pair; on the final pair, queue the run's results.
    function void note_pair(logic [ElemW-1:0] a, logic [ElemW-1:0] b, logic last);
      entry_t e;
      int unsigned hi, lo;
      if (loaded < StoreDepth) begin
        a_mem[loaded] = a;
        b_mem[loaded] = b;
        loaded++;
      end else begin
        overflowed = 1;
      end
      if (!last) return;
      if (rows == 0 || rows > DefMaxRows || cols == 0 || cols > DefMaxCols ||
          overflowed || loaded != rows * cols) begin
        e = '{row: '0, col: '0, value: '0, status: 1'b1, last: 1'b1};
        pending_q.push_back(e);
      end else begin
        for (int unsigned p = 0; p < cols; p++) begin
          for (int unsigned q = 0; q < cols; q++) begin
            hi = (p > q) ? p : q;
            lo = (p > q) ? q : p;
            e.row    = p[IdxW-1:0];
            e.col    = q[IdxW-1:0];
            e.value  = column_dot(hi, lo);
            e.status = 1'b0;
            e.last   = (p == cols - 1 && q == cols - 1);
            pending_q.push_back(e);
          end
        end
      end
      loaded     = 0;
      overflowed = 0;
    endfunction

    // Compare one accepted result with the oldest expected entry.
    function void check_entry(entry_t got);
      entry_t exp;
      if (pending_q.size() == 0) begin
        $error("unexpected result row %0d col %0d", got.row, got.col);
        errors++;
        return;
      end
      exp = pending_q.pop_front();
      if (got.row !== exp.row) begin
        $error("row_index: expected %0d, got %0d", exp.row, got.row);
        errors++;
      end
      if (got.col !== exp.col) begin
        $error("col_index: expected %0d, got %0d", exp.col, got.col);
        errors++;
      end
      if (got.value !== exp.value) begin
        $error("entry_value: expected %0d, got %0d", exp.value, got.value);
        errors++;
      end
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        errors++;
      end
      if (got.last !== exp.last) begin
        $error("last_result: expected %0d, got %0d", exp.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = CfgRowCount;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                s_valid = 1'b0;
  logic                s_ready;
  logic [31:0]         s_data = '0;
  logic                s_last = 1'b0;
  logic                m_valid;
  logic                m_ready = 1'b0;
  logic [71:0]         m_data;
  logic                m_user;
  logic                m_last;

  cross_product_board board = new();
  bit                 hold_req = 0;
  int unsigned        cycles = 0;
  int unsigned        sent = 0;

  symmetric_cross_product_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),   // a_elem[15:0], b_elem[31:16]
    .s_axis_tlast_i  (s_last),   // last_elem
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),   // row_index[2:0], col_index[5:3], entry_value[69:6]
    .m_axis_tuser_o  (m_user),   // status
    .m_axis_tlast_o  (m_last)    // last_result
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one, often none at all.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 11) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Favor the extremes of the Q4.12 range, and zero.
  function automatic logic [ElemW-1:0] pick_elem();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return ElemW'($urandom);
    endcase
  endfunction

  // Receiver: random stalls; on request hold off for a long stretch.
  always @(posedge clk_i) begin
    if (hold_req) begin
      m_ready <= 1'b0;
      repeat (StallHold) @(posedge clk_i);
      hold_req = 0;
    end else begin
      m_ready <= (pick_gap() == 0) || ($urandom_range(0, 1) == 0);
    end
  end

  // Monitor: check every accepted result transaction.
  always @(posedge clk_i) begin
    entry_t got;
    if (rst_ni && m_valid && m_ready) begin
      got.row    = m_data[2:0];
      got.col    = m_data[5:3];
      got.value  = m_data[69:6];
      got.status = m_user;
      got.last   = m_last;
      board.check_entry(got);
    end
  end

  // Write both registers while the block is idle.
  task automatic write_config(logic [RowCntW-1:0] rows, logic [ColCntW-1:0] cols);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgRowCount;
    cfg_data <= CfgDataW'(rows);
    board.set_reg(CfgRowCount, CfgDataW'(rows));
    @(posedge clk_i);
    cfg_idx  <= CfgColCount;
    cfg_data <= CfgDataW'(cols);
    board.set_reg(CfgColCount, CfgDataW'(cols));
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Offer one element pair and hold it until the block takes it.
  task automatic send_pair(logic [ElemW-1:0] a, logic [ElemW-1:0] b, logic last);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {b, a};
    s_last  <= last;
    do @(posedge clk_i); while (!s_ready);
    board.note_pair(a, b, last);
    sent++;
  endtask

  // Send a run of count pairs, last_elem on the final one.
  task automatic send_run(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_pair(pick_elem(), pick_elem(), i == count - 1);
    end
  endtask

  // Drop valid and wait until every expected result has come, then let the
  // compute pipeline drain before touching the registers.
  task automatic settle();
    s_valid <= 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
  endtask

  initial begin
    int unsigned r, c, n;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: single-element runs at the extremes.
    write_config(1, 1);
    send_pair(16'h8000, 16'h8000, 1'b1);
    send_pair(16'h7fff, 16'h8000, 1'b1);
    send_pair(16'h7fff, 16'h7fff, 1'b1);
    settle();
    write_config(2, 2);
    send_pair(16'h8000, 16'h7fff, 1'b0);
    send_pair(16'hffff, 16'h0001, 1'b0);
    send_pair(16'h1234, 16'hedcb, 1'b0);
    send_pair(16'h7fff, 16'h8000, 1'b1);
    // Count mismatch: one pair short, then one too many.
    send_run(3);
    send_run(5);
    settle();
    // Registers out of range.
    write_config(0, 1);
    send_run(1);
    settle();
    write_config(9'd511, 4'd15);
    send_run(2);
    settle();
    write_config(1, 0);
    send_run(1);
    settle();
    write_config(1, 9);
    send_run(1);
    settle();
    write_config(RowCntW'(DefMaxRows + 1), 1);
    send_run(1);
    settle();

    // Random runs; the first one meets a long receiver hold-off while more
    // pairs keep coming, so the block backs up into its input.
    hold_req = 1;
    while (sent < ItemTarget) begin
      r = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 6);
      c = $urandom_range(1, 8);
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1) == 0) r = $urandom_range(DefMaxRows + 1, 511);
        else c = $urandom_range(9, 15);
      end
      write_config(RowCntW'(r), ColCntW'(c));
      for (int unsigned k = $urandom_range(1, 3); k > 0; k--) begin
        if (sent >= ItemTarget) break;
        n = r * c;
        if ($urandom_range(0, 5) == 0) n = (n > 1 && $urandom_range(0, 1) == 0) ? n - 1 : n + 1;
        if (n > RunCap) n = RunCap;
        send_run(n);
      end
      settle();
    end

    if (board.errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule

### filelist.f
hdl/scp_pkg.sv
hdl/scp_ram.sv
hdl/scp_front.sv
hdl/scp_queue.sv
hdl/scp_back.sv
hdl/symmetric_cross_product_unit.sv
hdl/scp_checker.sv
tb/sv/tb.sv
